### rtl/ntta_pkg.sv
// ----------------------------------------------------------------------------
// ntta_pkg
// Shared types, codes and helpers for the neighbour table with TTL ageing.
// ----------------------------------------------------------------------------
package ntta_pkg;

    localparam int ACTION_W    = 3;
    localparam int SLOT_OUT_W  = 4;
    localparam int COUNT_OUT_W = 5;
    localparam int LEN_IN_W    = 4;
    localparam int ID_IN_W     = 64;
    localparam int COUNT_GROUP = 8;

    localparam logic CMD_LEARN = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_REFRESHED = 3'd0,
        ACT_INSERTED  = 3'd1,
        ACT_DROPPED   = 3'd2,
        ACT_IGNORED   = 3'd3,
        ACT_TICK_DONE = 3'd4
    } action_t;

    typedef struct packed {
        logic capture;
        logic compare;
        logic resolve;
        logic tick;
        logic count_clear;
        logic count_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic learn_valid;
        logic count_last;
    } dp_status_t;

    function automatic logic [ID_IN_W-1:0] byte_mask(input logic [LEN_IN_W-1:0] len);
        logic [ID_IN_W-1:0] m;
        m = '0;
        for (int b = 0; b < ID_IN_W / 8; b++)
        begin
            m[b*8 +: 8] = (LEN_IN_W'(b) < len) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

### rtl/neighbor_table_with_ttl_aging.sv
// ----------------------------------------------------------------------------
// neighbor_table_with_ttl_aging
// Remote neighbour table with per-slot TTL ageing, one result per transaction.
// ----------------------------------------------------------------------------
// Takes one transaction at a time. A learn transaction runs through capture,
// parallel key compare across all slots, lowest-slot select and write, and
// result load before the next acceptance; an ignored learn goes from capture
// straight to result load. An ageing tick ages all slots in parallel, then the
// valid count is rebuilt eight slots per cycle. The result sits in an output
// register and is held while stalled.
// ----------------------------------------------------------------------------
module neighbor_table_with_ttl_aging #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ID_BYTES      = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic                             command,
    input  logic                             entry_valid,
    input  logic [7:0]                       port_index,
    input  logic [7:0]                       chassis_subtype,
    input  logic [ntta_pkg::LEN_IN_W-1:0]    chassis_len,
    input  logic [ntta_pkg::ID_IN_W-1:0]     chassis_bytes,
    input  logic [7:0]                       port_subtype,
    input  logic [ntta_pkg::LEN_IN_W-1:0]    port_len,
    input  logic [ntta_pkg::ID_IN_W-1:0]     port_bytes,
    input  logic [15:0]                      time_to_live,
    input  logic [15:0]                      capabilities,
    input  logic [15:0]                      enabled_capabilities,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [ntta_pkg::ACTION_W-1:0]    action,
    output logic [ntta_pkg::SLOT_OUT_W-1:0]  slot,
    output logic [ntta_pkg::COUNT_OUT_W-1:0] entry_count
);

    ntta_pkg::dp_cmd_t    cmd;
    ntta_pkg::dp_status_t status;

    ntta_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

    ntta_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ID_BYTES      (ID_BYTES)
    ) u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .status               (status),
        .command              (command),
        .entry_valid          (entry_valid),
        .port_index           (port_index),
        .chassis_subtype      (chassis_subtype),
        .chassis_len          (chassis_len),
        .chassis_bytes        (chassis_bytes),
        .port_subtype         (port_subtype),
        .port_len             (port_len),
        .port_bytes           (port_bytes),
        .time_to_live         (time_to_live),
        .capabilities         (capabilities),
        .enabled_capabilities (enabled_capabilities),
        .action               (action),
        .slot                 (slot),
        .entry_count          (entry_count)
    );

endmodule

### rtl/ntta_ctrl.sv
// ----------------------------------------------------------------------------
// ntta_ctrl
// Sequencer for the neighbour table: learn, ageing tick, count and result.
// ----------------------------------------------------------------------------
module ntta_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    output logic                 result_valid,
    input  logic                 result_stall,
    output ntta_pkg::dp_cmd_t    cmd,
    input  ntta_pkg::dp_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_RESOLVE,
        ST_TICK,
        ST_COUNT,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    if (status.is_tick)
                        state_next = ST_TICK;
                    else if (status.learn_valid)
                        state_next = ST_COMPARE;
                    else
                        state_next = ST_RESULT;
                end
            end
            ST_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                cmd.resolve = 1'b1;
                state_next  = ST_RESULT;
            end
            ST_TICK:
            begin
                cmd.tick        = 1'b1;
                cmd.count_clear = 1'b1;
                state_next      = ST_COUNT;
            end
            ST_COUNT:
            begin
                cmd.count_step = 1'b1;
                if (status.count_last)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;

endmodule

### rtl/ntta_datapath.sv
// ----------------------------------------------------------------------------
// ntta_datapath
// Slot lanes, key compare, lowest-slot select, TTL ageing and valid count.
// ----------------------------------------------------------------------------
module ntta_datapath #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ID_BYTES      = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ntta_pkg::dp_cmd_t                    cmd,
    output ntta_pkg::dp_status_t                 status,
    input  logic                                 command,
    input  logic                                 entry_valid,
    input  logic [7:0]                           port_index,
    input  logic [7:0]                           chassis_subtype,
    input  logic [ntta_pkg::LEN_IN_W-1:0]        chassis_len,
    input  logic [ntta_pkg::ID_IN_W-1:0]         chassis_bytes,
    input  logic [7:0]                           port_subtype,
    input  logic [ntta_pkg::LEN_IN_W-1:0]        port_len,
    input  logic [ntta_pkg::ID_IN_W-1:0]         port_bytes,
    input  logic [15:0]                          time_to_live,
    input  logic [15:0]                          capabilities,
    input  logic [15:0]                          enabled_capabilities,
    output logic [ntta_pkg::ACTION_W-1:0]        action,
    output logic [ntta_pkg::SLOT_OUT_W-1:0]      slot,
    output logic [ntta_pkg::COUNT_OUT_W-1:0]     entry_count
);

    localparam int ID_W   = 8 * ID_BYTES;
    localparam int LEN_W  = $clog2(ID_BYTES + 1);
    localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int CW     = (CNT_W > ntta_pkg::COUNT_OUT_W) ? CNT_W : ntta_pkg::COUNT_OUT_W;
    localparam int GROUPS = (TABLE_ENTRIES + ntta_pkg::COUNT_GROUP - 1) / ntta_pkg::COUNT_GROUP;
    localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int PAD_W  = GROUPS * ntta_pkg::COUNT_GROUP;
    localparam int GC_W   = $clog2(ntta_pkg::COUNT_GROUP + 1);

    // captured item
    logic [7:0]       item_port_index_reg;
    logic [7:0]       item_chassis_subtype_reg;
    logic [LEN_W-1:0] item_chassis_len_reg;
    logic [ID_W-1:0]  item_chassis_bytes_reg;
    logic [7:0]       item_port_subtype_reg;
    logic [LEN_W-1:0] item_port_len_reg;
    logic [ID_W-1:0]  item_port_bytes_reg;
    logic [15:0]      item_ttl_reg;
    logic [31:0]      item_caps_reg;

    // slot lanes
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [7:0]               lane_port_index_reg     [TABLE_ENTRIES];
    logic [7:0]               lane_chassis_subtype_reg[TABLE_ENTRIES];
    logic [LEN_W-1:0]         lane_chassis_len_reg    [TABLE_ENTRIES];
    logic [ID_W-1:0]          lane_chassis_bytes_reg  [TABLE_ENTRIES];
    logic [7:0]               lane_port_subtype_reg   [TABLE_ENTRIES];
    logic [LEN_W-1:0]         lane_port_len_reg       [TABLE_ENTRIES];
    logic [ID_W-1:0]          lane_port_bytes_reg     [TABLE_ENTRIES];
    logic [15:0]              lane_ttl_reg            [TABLE_ENTRIES];
    logic [31:0]              caps_mem                [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] match_vec;
    logic [TABLE_ENTRIES-1:0] hit_vec_reg;
    logic [TABLE_ENTRIES-1:0] free_vec_reg;
    logic [TABLE_ENTRIES-1:0] hit_onehot;
    logic [TABLE_ENTRIES-1:0] free_onehot;
    logic [SLOT_W-1:0]        hit_idx;
    logic [SLOT_W-1:0]        free_idx;
    logic                     any_hit;
    logic                     any_free;
    logic                     do_insert;

    logic [ntta_pkg::LEN_IN_W-1:0] chassis_len_clamped;
    logic [ntta_pkg::LEN_IN_W-1:0] port_len_clamped;
    logic [ntta_pkg::ID_IN_W-1:0]  chassis_masked;
    logic [ntta_pkg::ID_IN_W-1:0]  port_masked;

    ntta_pkg::action_t res_action_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  acc_reg;
    logic [GRP_W-1:0]  grp_reg;
    logic [PAD_W-1:0]  valid_pad;
    logic [ntta_pkg::COUNT_GROUP-1:0] grp_bits;
    logic [GC_W-1:0]   grp_pop;
    logic [CW-1:0]     count_wide;

    logic [ntta_pkg::ACTION_W-1:0]    out_action_reg;
    logic [ntta_pkg::SLOT_OUT_W-1:0]  out_slot_reg;
    logic [ntta_pkg::COUNT_OUT_W-1:0] out_count_reg;

    assign status.is_tick     = (command == ntta_pkg::CMD_TICK);
    assign status.learn_valid = entry_valid;
    assign status.count_last  = (grp_reg == GRP_W'(GROUPS - 1));

    assign chassis_len_clamped = (chassis_len > ntta_pkg::LEN_IN_W'(ID_BYTES))
                               ? ntta_pkg::LEN_IN_W'(ID_BYTES) : chassis_len;
    assign port_len_clamped    = (port_len > ntta_pkg::LEN_IN_W'(ID_BYTES))
                               ? ntta_pkg::LEN_IN_W'(ID_BYTES) : port_len;
    assign chassis_masked = chassis_bytes & ntta_pkg::byte_mask(chassis_len_clamped);
    assign port_masked    = port_bytes & ntta_pkg::byte_mask(port_len_clamped);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_port_index_reg      <= port_index;
            item_chassis_subtype_reg <= chassis_subtype;
            item_chassis_len_reg     <= LEN_W'(chassis_len_clamped);
            item_chassis_bytes_reg   <= chassis_masked[ID_W-1:0];
            item_port_subtype_reg    <= port_subtype;
            item_port_len_reg        <= LEN_W'(port_len_clamped);
            item_port_bytes_reg      <= port_masked[ID_W-1:0];
            item_ttl_reg             <= time_to_live;
            item_caps_reg            <= {enabled_capabilities, capabilities};
        end
    end

    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            match_vec[i] = valid_reg[i]
                && (lane_port_index_reg[i]      == item_port_index_reg)
                && (lane_chassis_subtype_reg[i] == item_chassis_subtype_reg)
                && (lane_chassis_len_reg[i]     == item_chassis_len_reg)
                && (lane_chassis_bytes_reg[i]   == item_chassis_bytes_reg)
                && (lane_port_subtype_reg[i]    == item_port_subtype_reg)
                && (lane_port_len_reg[i]        == item_port_len_reg)
                && (lane_port_bytes_reg[i]      == item_port_bytes_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.compare)
        begin
            hit_vec_reg  <= match_vec;
            free_vec_reg <= ~valid_reg;
        end
    end

    // isolate the lowest set bit, then encode
    assign hit_onehot  = hit_vec_reg & (~hit_vec_reg + TABLE_ENTRIES'(1));
    assign free_onehot = free_vec_reg & (~free_vec_reg + TABLE_ENTRIES'(1));
    assign any_hit     = |hit_vec_reg;
    assign any_free    = |free_vec_reg;
    assign do_insert   = cmd.resolve && !any_hit && any_free;

    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (hit_onehot[i])
                hit_idx = hit_idx | SLOT_W'(i);
            if (free_onehot[i])
                free_idx = free_idx | SLOT_W'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (cmd.tick && valid_reg[i] && (lane_ttl_reg[i] == 16'd0))
                    valid_reg[i] <= 1'b0;
                else if (do_insert && free_onehot[i])
                    valid_reg[i] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (do_insert && free_onehot[i])
            begin
                lane_port_index_reg[i]      <= item_port_index_reg;
                lane_chassis_subtype_reg[i] <= item_chassis_subtype_reg;
                lane_chassis_len_reg[i]     <= item_chassis_len_reg;
                lane_chassis_bytes_reg[i]   <= item_chassis_bytes_reg;
                lane_port_subtype_reg[i]    <= item_port_subtype_reg;
                lane_port_len_reg[i]        <= item_port_len_reg;
                lane_port_bytes_reg[i]      <= item_port_bytes_reg;
                lane_ttl_reg[i]             <= item_ttl_reg;
            end
            else if (cmd.resolve && hit_onehot[i])
            begin
                lane_ttl_reg[i] <= item_ttl_reg;
            end
            else if (cmd.tick && valid_reg[i] && (lane_ttl_reg[i] != 16'd0))
            begin
                lane_ttl_reg[i] <= lane_ttl_reg[i] - 16'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_insert)
            caps_mem[free_idx] <= item_caps_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            res_action_reg <= ntta_pkg::ACT_IGNORED;
            res_slot_reg   <= '0;
        end
        else if (cmd.tick)
        begin
            res_action_reg <= ntta_pkg::ACT_TICK_DONE;
            res_slot_reg   <= '0;
        end
        else if (cmd.resolve)
        begin
            if (any_hit)
            begin
                res_action_reg <= ntta_pkg::ACT_REFRESHED;
                res_slot_reg   <= hit_idx;
            end
            else if (any_free)
            begin
                res_action_reg <= ntta_pkg::ACT_INSERTED;
                res_slot_reg   <= free_idx;
            end
            else
            begin
                res_action_reg <= ntta_pkg::ACT_DROPPED;
                res_slot_reg   <= '0;
            end
        end
    end

    // recount valid slots after a tick, one group per cycle
    assign valid_pad = PAD_W'(valid_reg);
    assign grp_bits  = valid_pad[grp_reg * ntta_pkg::COUNT_GROUP +: ntta_pkg::COUNT_GROUP];

    always_comb
    begin
        grp_pop = '0;
        for (int k = 0; k < ntta_pkg::COUNT_GROUP; k++)
        begin
            grp_pop = grp_pop + GC_W'(grp_bits[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            grp_reg   <= '0;
        end
        else
        begin
            if (do_insert)
                count_reg <= count_reg + CNT_W'(1);
            else if (cmd.count_step && status.count_last)
                count_reg <= acc_reg + CNT_W'(grp_pop);

            if (cmd.count_clear)
                grp_reg <= '0;
            else if (cmd.count_step)
                grp_reg <= grp_reg + GRP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.count_clear)
            acc_reg <= '0;
        else if (cmd.count_step)
            acc_reg <= acc_reg + CNT_W'(grp_pop);
    end

    assign count_wide = CW'(count_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_action_reg <= res_action_reg;
            out_slot_reg   <= ntta_pkg::SLOT_OUT_W'(res_slot_reg);
            out_count_reg  <= (count_wide > CW'(31)) ? ntta_pkg::COUNT_OUT_W'(31)
                                                     : ntta_pkg::COUNT_OUT_W'(count_wide);
        end
    end

    assign action      = out_action_reg;
    assign slot        = out_slot_reg;
    assign entry_count = out_count_reg;

endmodule

### sim/neighbor_table_with_ttl_aging_tb.sv
// ----------------------------------------------------------------------------
// neighbor_table_with_ttl_aging_tb
// Self-checking testbench for the neighbour table with TTL ageing.
// ----------------------------------------------------------------------------
// A tracker class keeps its own copy of the table and predicts the action,
// slot and valid count of every accepted transaction. A directed sequence
// covers length clamping, bytes past the length, refresh, near misses,
// ageing to invalidation and a full table. Random transactions follow, mostly
// re-advertising a pool of known neighbours so that refreshes, drops and
// expiry keep happening, under three phases of sender and receiver idling.
// ----------------------------------------------------------------------------
module neighbor_table_with_ttl_aging_tb;

    localparam int N_SLOTS        = 16;
    localparam int ID_LIMIT       = 8;
    localparam int KEY_POOL       = 24;
    localparam int RANDOM_ADVERTS = 1750;
    localparam int DRAIN_CYCLES   = 20;
    localparam int TIMEOUT_CYCLES = 400000;

    typedef struct packed {
        logic                           command;
        logic                           entry_valid;
        logic [7:0]                     port_index;
        logic [7:0]                     chassis_subtype;
        logic [ntta_pkg::LEN_IN_W-1:0]  chassis_len;
        logic [ntta_pkg::ID_IN_W-1:0]   chassis_bytes;
        logic [7:0]                     port_subtype;
        logic [ntta_pkg::LEN_IN_W-1:0]  port_len;
        logic [ntta_pkg::ID_IN_W-1:0]   port_bytes;
        logic [15:0]                    time_to_live;
        logic [15:0]                    capabilities;
        logic [15:0]                    enabled_capabilities;
    } advert_t;

    typedef struct packed {
        ntta_pkg::action_t                act;
        logic [ntta_pkg::SLOT_OUT_W-1:0]  slot;
        logic [ntta_pkg::COUNT_OUT_W-1:0] count;
    } outcome_t;

    function automatic logic [ntta_pkg::LEN_IN_W-1:0] clamp_len(
        input logic [ntta_pkg::LEN_IN_W-1:0] len);
        return (len > ID_LIMIT) ? ntta_pkg::LEN_IN_W'(ID_LIMIT) : len;
    endfunction

    function automatic logic [ntta_pkg::ID_IN_W-1:0] id_mask(
        input logic [ntta_pkg::LEN_IN_W-1:0] len);
        return (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
    endfunction

    class neighbor_table_tracker;
        bit                            in_use[N_SLOTS];
        logic [7:0]                    key_port_index[N_SLOTS];
        logic [7:0]                    key_chassis_subtype[N_SLOTS];
        logic [ntta_pkg::LEN_IN_W-1:0] key_chassis_len[N_SLOTS];
        logic [ntta_pkg::ID_IN_W-1:0]  key_chassis_bytes[N_SLOTS];
        logic [7:0]                    key_port_subtype[N_SLOTS];
        logic [ntta_pkg::LEN_IN_W-1:0] key_port_len[N_SLOTS];
        logic [ntta_pkg::ID_IN_W-1:0]  key_port_bytes[N_SLOTS];
        logic [15:0]                   ttl[N_SLOTS];
        logic [15:0]                   caps[N_SLOTS];
        logic [15:0]                   en_caps[N_SLOTS];
        outcome_t                      pending_outcomes[$];
        int                            errors;

        function new();
            errors = 0;
            foreach (in_use[i])
                in_use[i] = 1'b0;
        endfunction

        function void note_advert(advert_t a);
            outcome_t                      o;
            int                            hit;
            int                            free_i;
            logic [ntta_pkg::LEN_IN_W-1:0] cl;
            logic [ntta_pkg::LEN_IN_W-1:0] pl;
            logic [ntta_pkg::ID_IN_W-1:0]  cb;
            logic [ntta_pkg::ID_IN_W-1:0]  pb;
            o.act   = ntta_pkg::ACT_TICK_DONE;
            o.slot  = '0;
            o.count = '0;
            hit     = -1;
            free_i  = -1;
            if (a.command == ntta_pkg::CMD_TICK)
            begin
                for (int i = 0; i < N_SLOTS; i++)
                begin
                    if (in_use[i])
                    begin
                        if (ttl[i] != 16'd0)
                            ttl[i] = ttl[i] - 16'd1;
                        else
                            in_use[i] = 1'b0;
                    end
                end
            end
            else if (!a.entry_valid)
                o.act = ntta_pkg::ACT_IGNORED;
            else
            begin
                cl = clamp_len(a.chassis_len);
                pl = clamp_len(a.port_len);
                cb = a.chassis_bytes & id_mask(cl);
                pb = a.port_bytes & id_mask(pl);
                for (int i = 0; i < N_SLOTS; i++)
                begin
                    if (!in_use[i])
                    begin
                        if (free_i < 0)
                            free_i = i;
                    end
                    else if (hit < 0 && key_port_index[i] == a.port_index &&
                             key_chassis_subtype[i] == a.chassis_subtype &&
                             key_chassis_len[i] == cl && key_chassis_bytes[i] == cb &&
                             key_port_subtype[i] == a.port_subtype &&
                             key_port_len[i] == pl && key_port_bytes[i] == pb)
                        hit = i;
                end
                if (hit >= 0)
                begin
                    ttl[hit] = a.time_to_live;
                    o.act    = ntta_pkg::ACT_REFRESHED;
                    o.slot   = ntta_pkg::SLOT_OUT_W'(hit);
                end
                else if (free_i >= 0)
                begin
                    in_use[free_i]              = 1'b1;
                    key_port_index[free_i]      = a.port_index;
                    key_chassis_subtype[free_i] = a.chassis_subtype;
                    key_chassis_len[free_i]     = cl;
                    key_chassis_bytes[free_i]   = cb;
                    key_port_subtype[free_i]    = a.port_subtype;
                    key_port_len[free_i]        = pl;
                    key_port_bytes[free_i]      = pb;
                    ttl[free_i]                 = a.time_to_live;
                    caps[free_i]                = a.capabilities;
                    en_caps[free_i]             = a.enabled_capabilities;
                    o.act                       = ntta_pkg::ACT_INSERTED;
                    o.slot                      = ntta_pkg::SLOT_OUT_W'(free_i);
                end
                else
                    o.act = ntta_pkg::ACT_DROPPED;
            end
            for (int i = 0; i < N_SLOTS; i++)
                if (in_use[i])
                    o.count = o.count + 1'b1;
            pending_outcomes.push_back(o);
        endfunction

        function void check_outcome(logic [ntta_pkg::ACTION_W-1:0] act,
                                    logic [ntta_pkg::SLOT_OUT_W-1:0] sl,
                                    logic [ntta_pkg::COUNT_OUT_W-1:0] cnt);
            outcome_t e;
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result action %0d slot %0d count %0d",
                         $time, act, sl, cnt);
                errors++;
                return;
            end
            e = pending_outcomes.pop_front();
            if (act !== e.act)
            begin
                $display("%0t: action expected %0d actual %0d", $time, e.act, act);
                errors++;
            end
            if (sl !== e.slot)
            begin
                $display("%0t: slot expected %0d actual %0d", $time, e.slot, sl);
                errors++;
            end
            if (cnt !== e.count)
            begin
                $display("%0t: entry_count expected %0d actual %0d", $time, e.count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             item_valid;
    logic                             item_stall;
    logic                             command;
    logic                             entry_valid;
    logic [7:0]                       port_index;
    logic [7:0]                       chassis_subtype;
    logic [ntta_pkg::LEN_IN_W-1:0]    chassis_len;
    logic [ntta_pkg::ID_IN_W-1:0]     chassis_bytes;
    logic [7:0]                       port_subtype;
    logic [ntta_pkg::LEN_IN_W-1:0]    port_len;
    logic [ntta_pkg::ID_IN_W-1:0]     port_bytes;
    logic [15:0]                      time_to_live;
    logic [15:0]                      capabilities;
    logic [15:0]                      enabled_capabilities;
    logic                             result_valid;
    logic                             result_stall;
    logic [ntta_pkg::ACTION_W-1:0]    action;
    logic [ntta_pkg::SLOT_OUT_W-1:0]  slot;
    logic [ntta_pkg::COUNT_OUT_W-1:0] entry_count;

    neighbor_table_with_ttl_aging dut (.*);

    neighbor_table_tracker board;
    advert_t               key_pool[KEY_POOL];
    int                    send_idle_pct = 19;
    int                    recv_idle_pct = 78;

    function automatic advert_t random_advert();
        advert_t a;
        a.command              = 1'($urandom_range(1));
        a.entry_valid          = 1'($urandom_range(1));
        a.port_index           = 8'($urandom_range(255));
        a.chassis_subtype      = 8'($urandom_range(255));
        a.chassis_len          = ntta_pkg::LEN_IN_W'($urandom_range(15));
        a.chassis_bytes        = {$urandom, $urandom};
        a.port_subtype         = 8'($urandom_range(255));
        a.port_len             = ntta_pkg::LEN_IN_W'($urandom_range(15));
        a.port_bytes           = {$urandom, $urandom};
        a.time_to_live         = 16'($urandom_range(65535));
        a.capabilities         = 16'($urandom_range(65535));
        a.enabled_capabilities = 16'($urandom_range(65535));
        return a;
    endfunction

    function automatic advert_t make_advert(input int tick_pct);
        advert_t                      a;
        advert_t                      k;
        int                           r;
        int                           pick;
        logic [ntta_pkg::ID_IN_W-1:0] m;
        a = random_advert();
        r = $urandom_range(99);
        if (r < tick_pct)
        begin
            a.command = ntta_pkg::CMD_TICK;
            return a;
        end
        a.command     = ntta_pkg::CMD_LEARN;
        a.entry_valid = (r >= tick_pct + 8);
        if (r >= tick_pct + 18)
        begin
            k                 = key_pool[$urandom_range(KEY_POOL - 1)];
            a.port_index      = k.port_index;
            a.chassis_subtype = k.chassis_subtype;
            a.port_subtype    = k.port_subtype;
            a.chassis_len     = (k.chassis_len >= ID_LIMIT) ?
                                ntta_pkg::LEN_IN_W'($urandom_range(15, ID_LIMIT)) : k.chassis_len;
            a.port_len        = (k.port_len >= ID_LIMIT) ?
                                ntta_pkg::LEN_IN_W'($urandom_range(15, ID_LIMIT)) : k.port_len;
            m                 = id_mask(clamp_len(a.chassis_len));
            a.chassis_bytes   = (k.chassis_bytes & m) | (a.chassis_bytes & ~m);
            m                 = id_mask(clamp_len(a.port_len));
            a.port_bytes      = (k.port_bytes & m) | (a.port_bytes & ~m);
            if ($urandom_range(9) == 0)
            begin
                pick = $urandom_range(3);
                case (pick)
                    0: a.port_index = a.port_index ^ (8'd1 << $urandom_range(7));
                    1: a.chassis_subtype = a.chassis_subtype ^ (8'd1 << $urandom_range(7));
                    2: a.chassis_bytes = a.chassis_bytes ^ (64'd1 << $urandom_range(63));
                    default: a.port_len = a.port_len + 1'b1;
                endcase
            end
        end
        r = $urandom_range(99);
        if (r < 85)
            a.time_to_live = 16'($urandom_range(8));
        else if (r < 97)
            a.time_to_live = 16'($urandom_range(60, 9));
        return a;
    endfunction

    task automatic send_advert(input advert_t a);
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        command              <= a.command;
        entry_valid          <= a.entry_valid;
        port_index           <= a.port_index;
        chassis_subtype      <= a.chassis_subtype;
        chassis_len          <= a.chassis_len;
        chassis_bytes        <= a.chassis_bytes;
        port_subtype         <= a.port_subtype;
        port_len             <= a.port_len;
        port_bytes           <= a.port_bytes;
        time_to_live         <= a.time_to_live;
        capabilities         <= a.capabilities;
        enabled_capabilities <= a.enabled_capabilities;
        item_valid           <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        board.note_advert(a);
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #6 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 12);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        result_stall <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                board.check_outcome(action, slot, entry_count);
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        advert_t d;
        int      adverts_done;
        int      tick_pct;
        int      loop_n;
        board                 = new();
        adverts_done          = 0;
        tick_pct              = 25;
        loop_n                = 0;
        rst_n                <= 1'b0;
        item_valid           <= 1'b0;
        command              <= ntta_pkg::CMD_LEARN;
        entry_valid          <= 1'b0;
        port_index           <= '0;
        chassis_subtype      <= '0;
        chassis_len          <= '0;
        chassis_bytes        <= '0;
        port_subtype         <= '0;
        port_len             <= '0;
        port_bytes           <= '0;
        time_to_live         <= '0;
        capabilities         <= '0;
        enabled_capabilities <= '0;
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = random_advert();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tick on an empty table, learn fields all ones
        d         = '1;
        d.command = ntta_pkg::CMD_TICK;
        send_advert(d);
        d             = random_advert();
        d.command     = ntta_pkg::CMD_LEARN;
        d.entry_valid = 1'b0;
        send_advert(d);
        // lengths above the limit clamp; refresh keeps stored capabilities
        d         = '1;
        d.command = ntta_pkg::CMD_LEARN;
        send_advert(d);
        d.chassis_len          = 4'd8;
        d.port_len             = 4'd9;
        d.capabilities         = '0;
        d.enabled_capabilities = '0;
        send_advert(d);
        // zero lengths: every byte lies past the length
        d               = '0;
        d.entry_valid   = 1'b1;
        d.chassis_bytes = {$urandom, $urandom};
        d.port_bytes    = {$urandom, $urandom};
        d.time_to_live  = 16'd1;
        send_advert(d);
        d.chassis_bytes = {$urandom, $urandom};
        send_advert(d);
        d              = random_advert();
        d.command      = ntta_pkg::CMD_LEARN;
        d.entry_valid  = 1'b1;
        d.port_index   = 8'h40;
        d.chassis_len  = 4'd3;
        d.port_len     = 4'd3;
        d.time_to_live = 16'd0;
        send_advert(d);
        d.chassis_bytes[63:24] = {$urandom, 8'hA5};
        send_advert(d);
        // near miss inside the length
        d.chassis_bytes[0] = ~d.chassis_bytes[0];
        send_advert(d);
        // age: decrement, then drop entries already at zero
        d.command = ntta_pkg::CMD_TICK;
        send_advert(d);
        // fill the table, last one dropped
        for (int i = 0; i < 15; i++)
        begin
            d              = random_advert();
            d.command      = ntta_pkg::CMD_LEARN;
            d.entry_valid  = 1'b1;
            d.port_index   = 8'h20 + 8'(i);
            d.chassis_len  = ntta_pkg::LEN_IN_W'($urandom_range(15, 1));
            d.time_to_live = 16'($urandom_range(8));
            send_advert(d);
        end

        while (adverts_done < RANDOM_ADVERTS)
        begin
            if (adverts_done < RANDOM_ADVERTS / 3)
            begin
                send_idle_pct = 19;
                recv_idle_pct = 78;
            end
            else if (adverts_done < 2 * RANDOM_ADVERTS / 3)
            begin
                send_idle_pct = 78;
                recv_idle_pct = 19;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (loop_n % 100 == 0)
            begin
                case ($urandom_range(2))
                    0: tick_pct = 5;
                    1: tick_pct = 25;
                    default: tick_pct = 50;
                endcase
            end
            loop_n++;
            d = make_advert(tick_pct);
            send_advert(d);
            adverts_done++;
        end
        item_valid <= 1'b0;

        while (board.pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending_outcomes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
rtl/ntta_pkg.sv
rtl/ntta_ctrl.sv
rtl/ntta_datapath.sv
rtl/neighbor_table_with_ttl_aging.sv
sim/neighbor_table_with_ttl_aging_tb.sv
